FILE: sv/swnt_pkg.sv
// Shared types, constants and helpers for the sorted weighted neighbor table.
// Holds the channel payload structs, the status codes and the
// controller-datapath command and flag structs. Depends on nothing.
package swnt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH  = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int ID_W   = 16;
  localparam int WT_W   = 16;
  localparam int TOP_W  = 7;
  localparam int STAT_W = 3;

  // Request actions.
  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNCHANGED = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_ENTRY     = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic             action;
    logic [ID_W-1:0]  neighbor_id;
    logic [WT_W-1:0]  edge_weight;
    logic [TOP_W-1:0] top_count;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   entry_id;
    logic [WT_W-1:0]   entry_weight;
    logic              last;
  } rsp_t;

  // One stored table entry.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [WT_W-1:0] weight;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              start_set;
    logic              start_query;
    logic              find_next;
    logic              del_begin;
    logic              del_step;
    logic              dec_count;
    logic              ins_prep;
    logic              ins_shift;
    logic              ins_put;
    logic              set_status;
    logic [STAT_W-1:0] status_code;
    logic              emit_result;
    logic              emit_entry;
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic req_query;
    logic query_empty;
    logic idx_at_count;
    logic idx_at_top;
    logic idx_zero;
    logic id_match;
    logic weight_match;
    logic new_first;
    logic full;
    logic query_last;
    logic out_free;
  } flags_t;

  // True when entry (wa, ia) sorts strictly ahead of entry (wb, ib).
  function automatic logic ranks_before(input logic [WT_W-1:0] wa, input logic [ID_W-1:0] ia,
                                        input logic [WT_W-1:0] wb, input logic [ID_W-1:0] ib);
    logic result;
    if (wa != wb) begin
      result = (wa > wb);
    end else begin
      result = (ia > ib);
    end
    return result;
  endfunction

endpackage

FILE: sv/swnt_dp.sv
// Datapath of the sorted weighted neighbor table: entry memory, entry count,
// scan index, request holding registers and the result register.
// Depends on swnt_pkg.
module swnt_dp (
  input  logic            clk,
  input  logic            rst,
  input  swnt_pkg::req_t  req,
  input  swnt_pkg::cmd_t  cmd,
  input  logic            rsp_stall,
  output swnt_pkg::flags_t flags,
  output logic            rsp_valid,
  output swnt_pkg::rsp_t  rsp
);
  import swnt_pkg::*;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  top_n;
  logic [CNT_W-1:0]  query_n;
  logic [CNT_W-1:0]  idx_p1;
  logic [CNT_W-1:0]  idx_p2;
  logic [CNT_W-1:0]  idx_m1;
  logic [CNT_W-1:0]  idx_m2;
  logic [ID_W-1:0]   new_id;
  logic [WT_W-1:0]   new_weight;
  logic [STAT_W-1:0] result_code;

  assign idx_p1 = idx + CNT_W'(1);
  assign idx_p2 = idx + CNT_W'(2);
  assign idx_m1 = idx - CNT_W'(1);
  assign idx_m2 = idx - CNT_W'(2);

  // Number of entries a query lists: the smallest of request, fill and limit.
  always_comb begin
    int n;
    n = int'(req.top_count);
    if (int'(count) < n) begin
      n = int'(count);
    end
    if (RESULT_LIMIT < n) begin
      n = RESULT_LIMIT;
    end
    query_n = CNT_W'(n);
  end

  // Read address selection; each scan step prefetches the entry it needs next.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.start_set || cmd.start_query) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.find_next || cmd.del_begin || cmd.emit_entry) begin
      rd_en   = 1'b1;
      rd_addr = idx_p1[ADDR_W-1:0];
    end else if (cmd.del_step) begin
      rd_en   = 1'b1;
      rd_addr = idx_p2[ADDR_W-1:0];
    end else if (cmd.ins_prep) begin
      rd_en   = 1'b1;
      rd_addr = idx_m1[ADDR_W-1:0];
    end else if (cmd.ins_shift) begin
      rd_en   = 1'b1;
      rd_addr = idx_m2[ADDR_W-1:0];
    end
  end

  // Writes move an entry one place, or drop the new entry into its slot.
  assign wr_en   = cmd.del_step || cmd.ins_shift || cmd.ins_put;
  assign wr_addr = idx[ADDR_W-1:0];
  assign wr_data = cmd.ins_put ? entry_t'{id: new_id, weight: new_weight} : rd_data;

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entry count and scan index.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.ins_put) begin
        count <= count + CNT_W'(1);
      end else if (cmd.dec_count) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.start_set || cmd.start_query) begin
        idx <= '0;
      end else if (cmd.find_next || cmd.del_step || cmd.emit_entry) begin
        idx <= idx_p1;
      end else if (cmd.ins_shift) begin
        idx <= idx_m1;
      end
    end
  end

  // Request holding registers.
  always_ff @(posedge clk) begin
    if (cmd.start_set) begin
      new_id     <= req.neighbor_id;
      new_weight <= req.edge_weight;
    end
    if (cmd.start_query) begin
      top_n <= query_n;
    end
    if (cmd.set_status) begin
      result_code <= cmd.status_code;
    end
  end

  // Result register; it frees up in the cycle its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit_result || cmd.emit_entry) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_result) begin
      rsp <= rsp_t'{status: result_code, entry_id: '0, entry_weight: '0, last: 1'b1};
    end else if (cmd.emit_entry) begin
      rsp <= rsp_t'{status: ST_ENTRY, entry_id: rd_data.id, entry_weight: rd_data.weight,
                    last: flags.query_last};
    end
  end

  // Status back to the controller.
  always_comb begin
    flags.req_query    = (req.action == ACT_QUERY);
    flags.query_empty  = (query_n == '0);
    flags.idx_at_count = (idx == count);
    flags.idx_at_top   = (idx_p1 == count);
    flags.idx_zero     = (idx == '0);
    flags.id_match     = (rd_data.id == new_id);
    flags.weight_match = (rd_data.weight == new_weight);
    flags.new_first    = ranks_before(new_weight, new_id, rd_data.weight, rd_data.id);
    flags.full         = (count == CNT_W'(TABLE_DEPTH));
    flags.query_last   = (idx_p1 == top_n);
    flags.out_free     = !rsp_valid || !rsp_stall;
  end

  // The fill never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // An entry is only placed when there is room for it.
  a_put_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_put |-> !flags.full)
    else $error("insert into a full table");

  // Removal only happens on a non-empty table.
  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.dec_count |-> (count != '0))
    else $error("entry count underflow");

  // A result is never loaded over one that is still waiting.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_result || cmd.emit_entry) |-> flags.out_free)
    else $error("result register overwritten");

endmodule

FILE: sv/swnt_ctrl.sv
// Controller of the sorted weighted neighbor table: sequences the search,
// delete shift, insert shift and listing passes over the datapath.
// Depends on swnt_pkg.
module swnt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  swnt_pkg::flags_t flags,
  output logic             req_stall,
  output swnt_pkg::cmd_t   cmd
);
  import swnt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_DEL    = 3'd2;
  localparam logic [2:0] S_INS    = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;
  localparam logic [2:0] S_QUERY  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (flags.req_query) begin
            if (flags.query_empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next      = S_RESULT;
            end else begin
              cmd.start_query = 1'b1;
              state_next      = S_QUERY;
            end
          end else begin
            cmd.start_set = 1'b1;
            state_next    = S_FIND;
          end
        end
      end
      // Linear search for the id, one entry per cycle.
      S_FIND: begin
        if (flags.idx_at_count) begin
          cmd.set_status = 1'b1;
          if (flags.full) begin
            cmd.status_code = ST_FULL;
            state_next      = S_RESULT;
          end else begin
            cmd.status_code = ST_INSERTED;
            cmd.ins_prep    = 1'b1;
            state_next      = S_INS;
          end
        end else if (flags.id_match) begin
          cmd.set_status = 1'b1;
          if (flags.weight_match) begin
            cmd.status_code = ST_UNCHANGED;
            state_next      = S_RESULT;
          end else begin
            cmd.status_code = ST_UPDATED;
            cmd.del_begin   = 1'b1;
            state_next      = S_DEL;
          end
        end else begin
          cmd.find_next = 1'b1;
        end
      end
      // Close the gap left by the old entry.
      S_DEL: begin
        if (flags.idx_at_top) begin
          cmd.dec_count = 1'b1;
          cmd.ins_prep  = 1'b1;
          state_next    = S_INS;
        end else begin
          cmd.del_step = 1'b1;
        end
      end
      // Insertion from the tail: move lower-ranked entries down one place.
      S_INS: begin
        if (!flags.idx_zero && flags.new_first) begin
          cmd.ins_shift = 1'b1;
        end else begin
          cmd.ins_put = 1'b1;
          state_next  = S_RESULT;
        end
      end
      S_RESULT: begin
        if (flags.out_free) begin
          cmd.emit_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      // One listed entry per transfer.
      S_QUERY: begin
        if (flags.out_free) begin
          cmd.emit_entry = 1'b1;
          if (flags.query_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/sorted_weighted_neighbor_table.sv
// Sorted weighted neighbor table: keeps up to 64 neighbor ids with weights,
// ordered by weight descending and then by id descending. Uses swnt_pkg,
// swnt_ctrl and swnt_dp.
// Request channel (req_valid, req_stall, req): a set request inserts or moves
// an id and yields one result with status inserted, updated, unchanged or
// full. A query request yields the best min(top_count, fill) entries in order,
// last set on the final one, or a single list-empty result.
// Response channel (rsp_valid, rsp_stall, rsp): one registered result; a set
// keeps working while a result waits, and the block only loads the next result
// once the waiting one has transferred.
// Timing: one request at a time. A query loads its entries into the result
// register in order, one entry per cycle while the receiver does not stall. A
// set scans the table one entry per cycle through the single memory read port.
// A new id is searched past all held entries and then placed by moving
// lower-ranked entries down from the tail; an id already held is found, its
// old slot is closed by moving the entries below it up, and it is placed anew.
// The next request is taken in the cycle after the last result is loaded.
// Reset empties the table at once; no clearing pass is needed. A stalled
// receiver holds the result register: a query waits on it entry by entry,
// while a set finishes its scan and waits only to load its result.
module sorted_weighted_neighbor_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  swnt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output swnt_pkg::rsp_t rsp
);
  import swnt_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  swnt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .flags     (flags),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  swnt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .flags     (flags),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

FILE: tb/swnt_table_checker.sv
// Checker for the sorted weighted neighbor table: keeps its own ordered copy of
// the table, works out the results of every accepted request and compares them
// with the response transfers. Depends on swnt_pkg.
module swnt_table_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  swnt_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  swnt_pkg::rsp_t rsp,
  output int             fail_count,
  output int             awaited_count
);
  import swnt_pkg::*;

  localparam int SHOWN_MAX = 10;

  // Mirror of the table, best entry first.
  logic [ID_W-1:0] mirror_id [TABLE_DEPTH];
  logic [WT_W-1:0] mirror_wt [TABLE_DEPTH];
  int              mirror_fill;

  // Results still owed by the block, oldest first.
  rsp_t awaited_rsp [$];

  int failures    = 0;
  int shown       = 0;
  int awaited_num = 0;

  assign fail_count    = failures;
  assign awaited_count = awaited_num;

  // Heavier weight wins; on equal weight the larger id wins.
  function automatic logic outranks(input logic [WT_W-1:0] wa, input logic [ID_W-1:0] ia,
                                    input logic [WT_W-1:0] wb, input logic [ID_W-1:0] ib);
    return {wa, ia} > {wb, ib};
  endfunction

  function automatic rsp_t make_rsp(input logic [STAT_W-1:0] st, input logic [ID_W-1:0] id,
                                    input logic [WT_W-1:0] wt, input logic fin);
    rsp_t r;
    r.status       = st;
    r.entry_id     = id;
    r.entry_weight = wt;
    r.last         = fin;
    return r;
  endfunction

  // Append one result to the tail of the owed list.
  task automatic owe_rsp(input rsp_t r);
    awaited_rsp = {awaited_rsp, r};
  endtask

  // Insert an entry at its ranked slot, moving lower entries down by one.
  task automatic place_entry(input logic [ID_W-1:0] id, input logic [WT_W-1:0] wt);
    int pos;
    pos = 0;
    while (pos < mirror_fill && outranks(mirror_wt[pos], mirror_id[pos], wt, id)) pos++;
    for (int i = mirror_fill; i > pos; i--) begin
      mirror_id[i] = mirror_id[i-1];
      mirror_wt[i] = mirror_wt[i-1];
    end
    mirror_id[pos] = id;
    mirror_wt[pos] = wt;
    mirror_fill++;
  endtask

  // Close the slot at pos, moving lower entries up by one.
  task automatic drop_entry(input int pos);
    for (int i = pos; i + 1 < mirror_fill; i++) begin
      mirror_id[i] = mirror_id[i+1];
      mirror_wt[i] = mirror_wt[i+1];
    end
    mirror_fill--;
  endtask

  // Apply one request to the mirror and queue the results it must produce.
  task automatic predict_request(input req_t r);
    int   pos;
    int   n;
    logic found;
    if (r.action == ACT_SET) begin
      found = 1'b0;
      pos   = 0;
      for (int i = 0; i < mirror_fill; i++) begin
        if (!found && mirror_id[i] == r.neighbor_id) begin
          found = 1'b1;
          pos   = i;
        end
      end
      if (found) begin
        if (mirror_wt[pos] == r.edge_weight) begin
          owe_rsp(make_rsp(ST_UNCHANGED, '0, '0, 1'b1));
        end else begin
          drop_entry(pos);
          place_entry(r.neighbor_id, r.edge_weight);
          owe_rsp(make_rsp(ST_UPDATED, '0, '0, 1'b1));
        end
      end else if (mirror_fill >= TABLE_DEPTH) begin
        owe_rsp(make_rsp(ST_FULL, '0, '0, 1'b1));
      end else begin
        place_entry(r.neighbor_id, r.edge_weight);
        owe_rsp(make_rsp(ST_INSERTED, '0, '0, 1'b1));
      end
    end else begin
      n = r.top_count;
      if (n > mirror_fill) n = mirror_fill;
      if (n > RESULT_LIMIT) n = RESULT_LIMIT;
      if (n == 0) begin
        owe_rsp(make_rsp(ST_EMPTY, '0, '0, 1'b1));
      end else begin
        for (int k = 0; k < n; k++) begin
          owe_rsp(make_rsp(ST_ENTRY, mirror_id[k], mirror_wt[k], k == n - 1));
        end
      end
    end
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (shown < SHOWN_MAX) begin
      shown++;
      $display("%s", msg);
    end
  endtask

  // Check response transfers first, then fold in the request taken at this edge.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      awaited_rsp.delete();
      mirror_fill = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d id %h weight %h last %b",
                                 rsp.status, rsp.entry_id, rsp.entry_weight, rsp.last));
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status || rsp.entry_id !== want.entry_id ||
              rsp.entry_weight !== want.entry_weight || rsp.last !== want.last) begin
            note_failure($sformatf({"result mismatch: expected status %0d id %h weight %h ",
                                    "last %b, got status %0d id %h weight %h last %b"},
                                   want.status, want.entry_id, want.entry_weight, want.last,
                                   rsp.status, rsp.entry_id, rsp.entry_weight, rsp.last));
          end
        end
      end
      if (req_valid && !req_stall) predict_request(req);
    end
    awaited_num = awaited_rsp.size();
  end

endmodule

FILE: tb/sorted_weighted_neighbor_table_tb.sv
// Testbench top for the sorted weighted neighbor table: clock, reset, request
// stimulus, response back-pressure and the verdict. Depends on swnt_pkg, the
// block under test and swnt_table_checker.
module sorted_weighted_neighbor_table_tb;
  import swnt_pkg::*;

  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 293;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_SIZE    = 72;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int fail_count;
  int awaited_count;
  int accepted    = 0;
  int cycle_count = 0;

  // Ids that random sets revisit, with the weight each was last given.
  logic [ID_W-1:0] id_pool [POOL_SIZE];
  logic [WT_W-1:0] pool_wt [POOL_SIZE];

  sorted_weighted_neighbor_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  swnt_table_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one request, idling at random first, and hold it until the transfer.
  task automatic send_request(input req_t item);
    while (!(accepted >= 150 && accepted < 230) && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    accepted++;
  endtask

  // Set request; the unused count field carries noise.
  task automatic send_set(input logic [ID_W-1:0] id, input logic [WT_W-1:0] wt);
    req_t item;
    item.action      = ACT_SET;
    item.neighbor_id = id;
    item.edge_weight = wt;
    item.top_count   = TOP_W'($urandom_range(0, 64));
    send_request(item);
  endtask

  // Query request; the unused id and weight fields carry noise.
  task automatic send_query(input logic [TOP_W-1:0] top);
    req_t item;
    item.action      = ACT_QUERY;
    item.neighbor_id = ID_W'($urandom_range(0, 65535));
    item.edge_weight = WT_W'($urandom_range(0, 65535));
    item.top_count   = top;
    send_request(item);
  endtask

  // Response side: random stalls, a quiet stretch, and one long hold-off
  // that backs the block up into its request channel.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted >= 100) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= (accepted >= 190 && accepted < 260) ? 1'b0
                 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Request stimulus and verdict.
  initial begin
    int              pick;
    int              slot;
    int              query_pct;
    bit              stranger;
    logic [ID_W-1:0] id;
    logic [WT_W-1:0] wt;
    logic [TOP_W-1:0] top;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      id_pool[i] = ID_W'($urandom_range(0, 65535));
      pool_wt[i] = WT_W'($urandom_range(0, 3));
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, ties, extreme values, weight moves up and down.
    send_query(7'd5);
    send_query(7'd0);
    send_set(16'h1234, 16'd100);
    send_query(7'd0);
    send_set(16'h1234, 16'd100);
    send_set(16'hFFFF, 16'hFFFF);
    send_set(16'h0000, 16'h0000);
    send_set(16'h0001, 16'd100);
    send_set(16'hAAAA, 16'd100);
    send_set(16'h5555, 16'h8000);
    send_set(16'h1234, 16'd7);
    send_set(16'h0000, 16'hFFFF);
    send_set(16'h0001, 16'h0000);
    send_query(7'd64);
    send_query(7'd1);
    send_query(7'd3);
    send_query(7'd6);

    // Random: mostly sets early so the table fills, then a richer query mix.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick      = $urandom_range(0, 99);
      query_pct = (n < 140) ? 15 : 40;
      if (pick < query_pct) begin
        case ($urandom_range(0, 3))
          0:       top = 7'd64;
          1:       top = TOP_W'($urandom_range(0, 3));
          default: top = TOP_W'($urandom_range(0, 64));
        endcase
        send_query(top);
      end else begin
        stranger = ($urandom_range(0, 9) == 0);
        slot     = $urandom_range(0, POOL_SIZE - 1);
        id       = stranger ? ID_W'($urandom_range(0, 65535)) : id_pool[slot];
        case ($urandom_range(0, 3))
          0:       wt = stranger ? WT_W'($urandom_range(0, 65535)) : pool_wt[slot];
          1:       wt = WT_W'($urandom_range(0, 3));
          2:       wt = WT_W'($urandom_range(65532, 65535));
          default: wt = WT_W'($urandom_range(0, 65535));
        endcase
        if (!stranger) pool_wt[slot] = wt;
        send_set(id, wt);
      end
    end
    req_valid <= 1'b0;

    // Drain the outstanding results, then allow for any late stray transfer.
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
